// ===== hw/rtl/pwhg_pkg.sv =====
// Shared types and constants of the proximity wave and hold gesture detector.
package pwhg_pkg;

   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 32;
   localparam int THRESHOLD_BITS = 16;
   localparam int FRAMES_BITS = 8;
   localparam int COUNT_BITS = 16;

   localparam logic [CSR_ADDR_BITS-1:0] CSR_ADDR_THRESHOLD = 4'h0;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_ADDR_WAVE_MIN = 4'h4;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_ADDR_HOLD_MIN = 4'h8;

   localparam logic [THRESHOLD_BITS-1:0] THRESHOLD_RESET = 16'd18;
   localparam logic [FRAMES_BITS-1:0] WAVE_MIN_RESET = 8'd1;
   localparam logic [FRAMES_BITS-1:0] HOLD_MIN_RESET = 8'd20;

   typedef enum logic [3:0] {
      MODE_IDLE  = 4'b0001,
      MODE_ARMED = 4'b0010,
      MODE_LEVEL = 4'b0100,
      MODE_HOLD  = 4'b1000
   } mode_type;

   typedef enum logic [1:0] {
      MOTION_NONE = 2'd0,
      MOTION_EXIT = 2'd1,
      MOTION_WAVE = 2'd2,
      MOTION_HOLD = 2'd3
   } gesture_type;

   typedef struct packed {
      logic [THRESHOLD_BITS-1:0] detect_threshold;
      logic [FRAMES_BITS-1:0]    wave_min_frames;
      logic [FRAMES_BITS-1:0]    hold_min_frames;
   } cfg_type;

endpackage

// ===== hw/rtl/proximity_wave_hold_gesture_detector.sv =====
// Top level of the proximity wave and hold gesture detector.
// One sample word in gives one result word out. A word is captured in an input
// register, runs through the baseline filter and gesture state machine and
// lands in a result register; while rsp_ready is high a new word can be taken
// every cycle, so the sustained rate is one word per clock, and rsp_valid rises
// once the word has passed the input register and then the result register; the
// state update between them is combinational. Registers: detect_threshold at 0x0,
// wave_min_frames at 0x4, hold_min_frames at 0x8; write them only while idle.
module proximity_wave_hold_gesture_detector #(
   parameter int SAMPLE_BITS = 16,
   parameter int BASELINE_SHIFT = 5
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [SAMPLE_BITS-1:0]              req_prox,
   input  logic                                req_clear_counts,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [1:0]                          rsp_gesture,
   output logic [pwhg_pkg::COUNT_BITS-1:0]     rsp_wave_total,
   output logic [pwhg_pkg::COUNT_BITS-1:0]     rsp_hold_total,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [pwhg_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [pwhg_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [pwhg_pkg::CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                                csr_pready
);
   import pwhg_pkg::*;

   cfg_type                 cfg;
   logic                    advance;
   logic                    in_take;
   logic                    in_valid_ff, in_valid_in;
   logic [SAMPLE_BITS-1:0]  in_prox_ff;
   logic                    in_clear_ff;
   logic                    out_valid_ff, out_valid_in;
   logic [1:0]              out_gesture_ff;
   logic [COUNT_BITS-1:0]   out_wave_ff;
   logic [COUNT_BITS-1:0]   out_hold_ff;
   gesture_type             core_gesture;
   logic [COUNT_BITS-1:0]   core_wave;
   logic [COUNT_BITS-1:0]   core_hold;

   pwhg_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   pwhg_core #(
      .SAMPLE_BITS    (SAMPLE_BITS),
      .BASELINE_SHIFT (BASELINE_SHIFT)
   ) u_core (
      .clock        (clock),
      .reset        (reset),
      .step         (advance),
      .prox         (in_prox_ff),
      .clear_counts (in_clear_ff),
      .cfg          (cfg),
      .gesture      (core_gesture),
      .wave_total   (core_wave),
      .hold_total   (core_hold)
   );

   assign advance = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign in_take = req_valid && req_ready;
   assign in_valid_in = in_take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_take) begin
         in_prox_ff <= req_prox;
         in_clear_ff <= req_clear_counts;
      end
      if (advance) begin
         out_gesture_ff <= core_gesture;
         out_wave_ff <= core_wave;
         out_hold_ff <= core_hold;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_gesture = out_gesture_ff;
   assign rsp_wave_total = out_wave_ff;
   assign rsp_hold_total = out_hold_ff;

endmodule

// ===== hw/rtl/pwhg_csr.sv =====
// Configuration register file with its APB-style access port.
module pwhg_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [pwhg_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [pwhg_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [pwhg_pkg::CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                                csr_pready,
   output pwhg_pkg::cfg_type                   cfg
);
   import pwhg_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic    write_en;

   assign csr_pready = 1'b1;
   assign write_en = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         unique case (csr_paddr)
            CSR_ADDR_THRESHOLD: cfg_in.detect_threshold = csr_pwdata[THRESHOLD_BITS-1:0];
            CSR_ADDR_WAVE_MIN:  cfg_in.wave_min_frames = csr_pwdata[FRAMES_BITS-1:0];
            CSR_ADDR_HOLD_MIN:  cfg_in.hold_min_frames = csr_pwdata[FRAMES_BITS-1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr)
         CSR_ADDR_THRESHOLD: csr_prdata = {{(CSR_DATA_BITS-THRESHOLD_BITS){1'b0}},
                                           cfg_ff.detect_threshold};
         CSR_ADDR_WAVE_MIN:  csr_prdata = {{(CSR_DATA_BITS-FRAMES_BITS){1'b0}},
                                           cfg_ff.wave_min_frames};
         CSR_ADDR_HOLD_MIN:  csr_prdata = {{(CSR_DATA_BITS-FRAMES_BITS){1'b0}},
                                           cfg_ff.hold_min_frames};
         default:            csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.detect_threshold <= THRESHOLD_RESET;
         cfg_ff.wave_min_frames <= WAVE_MIN_RESET;
         cfg_ff.hold_min_frames <= HOLD_MIN_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== hw/rtl/pwhg_core.sv =====
// Baseline tracker, gesture state machine and saturating counters.
module pwhg_core #(
   parameter int SAMPLE_BITS = 16,
   parameter int BASELINE_SHIFT = 5
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               step,
   input  logic [SAMPLE_BITS-1:0]             prox,
   input  logic                               clear_counts,
   input  pwhg_pkg::cfg_type                  cfg,
   output pwhg_pkg::gesture_type              gesture,
   output logic [pwhg_pkg::COUNT_BITS-1:0]    wave_total,
   output logic [pwhg_pkg::COUNT_BITS-1:0]    hold_total
);
   import pwhg_pkg::*;

   localparam int CMP_BITS = (SAMPLE_BITS > THRESHOLD_BITS) ? SAMPLE_BITS : THRESHOLD_BITS;

   mode_type                mode_ff, mode_in;
   logic [FRAMES_BITS-1:0]  run_ff, run_in;
   logic [SAMPLE_BITS-1:0]  baseline_ff, baseline_in;
   logic                    last_nonzero_ff, last_nonzero_in;
   logic [COUNT_BITS-1:0]   wave_ff, wave_in;
   logic [COUNT_BITS-1:0]   hold_ff, hold_in;

   logic [SAMPLE_BITS:0]    diff;
   logic [SAMPLE_BITS-1:0]  filtered;
   logic [SAMPLE_BITS-1:0]  impulse;
   logic                    exceeded;
   logic                    moved;
   logic                    run_over_hold;
   logic                    run_over_wave;
   logic                    count_wave;
   logic                    count_hold;
   logic [COUNT_BITS-1:0]   wave_base;
   logic [COUNT_BITS-1:0]   hold_base;
   mode_type                fsm_mode;
   gesture_type             fsm_gesture;
   logic [FRAMES_BITS-1:0]  run_inc;

   // a falling sample lands exactly on the clamp, so only a rise needs the divided step
   assign diff = {1'b0, prox} - {1'b0, baseline_ff};
   assign filtered = diff[SAMPLE_BITS] ? prox
                   : baseline_ff + (diff[SAMPLE_BITS-1:0] >> BASELINE_SHIFT);
   assign impulse = prox - filtered;
   assign exceeded = CMP_BITS'(impulse) > CMP_BITS'(cfg.detect_threshold);

   assign run_over_hold = run_ff > cfg.hold_min_frames;
   assign run_over_wave = run_ff > cfg.wave_min_frames;
   assign run_inc = (run_ff == {FRAMES_BITS{1'b1}}) ? run_ff : run_ff + 1'b1;

   always_comb begin
      fsm_mode = mode_ff;
      fsm_gesture = MOTION_NONE;
      moved = 1'b0;
      count_wave = 1'b0;
      count_hold = 1'b0;
      unique case (mode_ff)
         MODE_IDLE: begin
            fsm_gesture = MOTION_EXIT;
            moved = 1'b1;
            fsm_mode = exceeded ? MODE_LEVEL : MODE_ARMED;
         end
         MODE_ARMED: begin
            if (exceeded) begin
               moved = 1'b1;
               fsm_mode = MODE_LEVEL;
            end
         end
         MODE_LEVEL: begin
            if (!exceeded || run_over_hold) begin
               moved = 1'b1;
               if (run_over_hold) begin
                  count_hold = 1'b1;
                  fsm_mode = MODE_HOLD;
                  fsm_gesture = MOTION_HOLD;
               end else if (run_over_wave) begin
                  count_wave = 1'b1;
                  fsm_mode = MODE_IDLE;
                  fsm_gesture = MOTION_WAVE;
               end else begin
                  fsm_mode = MODE_IDLE;
               end
            end
         end
         MODE_HOLD: begin
            if (!exceeded) begin
               moved = 1'b1;
               fsm_mode = MODE_IDLE;
            end
         end
         default: begin
            moved = 1'b1;
            fsm_mode = MODE_IDLE;
         end
      endcase
   end

   assign wave_base = clear_counts ? '0 : wave_ff;
   assign hold_base = clear_counts ? '0 : hold_ff;

   always_comb begin
      mode_in = mode_ff;
      run_in = run_ff;
      baseline_in = prox;
      gesture = MOTION_NONE;
      wave_in = wave_base;
      hold_in = hold_base;
      if (last_nonzero_ff) begin
         mode_in = fsm_mode;
         gesture = fsm_gesture;
         if (!exceeded) begin
            run_in = '0;
         end else if (moved) begin
            run_in = FRAMES_BITS'(1);
         end else begin
            run_in = run_inc;
         end
         if (!(mode_ff != MODE_IDLE && fsm_mode == MODE_IDLE)) begin
            baseline_in = filtered;
         end
         if (count_wave && wave_base != {COUNT_BITS{1'b1}}) begin
            wave_in = wave_base + 1'b1;
         end
         if (count_hold && hold_base != {COUNT_BITS{1'b1}}) begin
            hold_in = hold_base + 1'b1;
         end
      end
   end

   assign last_nonzero_in = (prox != '0);
   assign wave_total = wave_in;
   assign hold_total = hold_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
         run_ff <= '0;
         baseline_ff <= '0;
         last_nonzero_ff <= 1'b0;
         wave_ff <= '0;
         hold_ff <= '0;
      end else if (step) begin
         mode_ff <= mode_in;
         run_ff <= run_in;
         baseline_ff <= baseline_in;
         last_nonzero_ff <= last_nonzero_in;
         wave_ff <= wave_in;
         hold_ff <= hold_in;
      end
   end

endmodule

// ===== test/proximity_wave_hold_gesture_detector_tb.sv =====
// Self-checking testbench of the proximity wave and hold gesture detector.
module proximity_wave_hold_gesture_detector_tb;
   import pwhg_pkg::*;

   localparam int PROX_BITS = 16;
   localparam int QUIET_LIMIT = 400;
   localparam int PHASE_WORDS = 200;

   typedef struct packed {
      gesture_type gesture;
      logic [COUNT_BITS-1:0] waves;
      logic [COUNT_BITS-1:0] holds;
   } tally_word_type;

   typedef struct packed {
      logic [PROX_BITS-1:0] prox;
      logic clear;
   } sample_word_type;

   typedef struct {
      logic [PROX_BITS-1:0] prox;
      logic clear;
      bit typed;
      gesture_type gesture;
      logic [COUNT_BITS-1:0] waves;
      logic [COUNT_BITS-1:0] holds;
   } script_row_type;

   logic clock = 1'b0;
   logic reset;
   logic req_valid;
   logic req_ready;
   logic [PROX_BITS-1:0] req_prox;
   logic req_clear_counts;
   logic rsp_valid;
   logic rsp_ready;
   logic [1:0] rsp_gesture;
   logic [COUNT_BITS-1:0] rsp_wave_total;
   logic [COUNT_BITS-1:0] rsp_hold_total;
   logic csr_psel;
   logic csr_penable;
   logic csr_pwrite;
   logic [CSR_ADDR_BITS-1:0] csr_paddr;
   logic [CSR_DATA_BITS-1:0] csr_pwdata;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic csr_pready;

   // predictor state
   cfg_type live_cfg;
   mode_type track_mode;
   logic [FRAMES_BITS-1:0] run_len;
   logic [PROX_BITS-1:0] floor_level;
   bit prev_live;
   logic [COUNT_BITS-1:0] wave_tally;
   logic [COUNT_BITS-1:0] hold_tally;

   tally_word_type awaited_tallies[$];
   sample_word_type script[$];
   tally_word_type no_tally;
   bit burst;
   int mismatches;
   int words_sent;
   int words_checked;
   int waves_predicted;
   int holds_predicted;
   int rsp_hold_off;
   int rsp_draw;

   script_row_type opening_rows [20] = '{
      '{16'd0,     1'b0, 1'b1, MOTION_NONE, 16'd0, 16'd0},
      '{16'd65535, 1'b1, 1'b1, MOTION_NONE, 16'd0, 16'd0},
      '{16'd65535, 1'b0, 1'b0, MOTION_NONE, 16'd0, 16'd0},
      '{16'd1,     1'b0, 1'b0, MOTION_NONE, 16'd0, 16'd0},
      '{16'd2000,  1'b0, 1'b0, MOTION_NONE, 16'd0, 16'd0},
      '{16'd2000,  1'b0, 1'b0, MOTION_NONE, 16'd0, 16'd0},
      '{16'd100,   1'b0, 1'b0, MOTION_NONE, 16'd0, 16'd0},
      '{16'd100,   1'b0, 1'b0, MOTION_NONE, 16'd0, 16'd0},
      '{16'd118,   1'b0, 1'b0, MOTION_NONE, 16'd0, 16'd0},
      '{16'd119,   1'b0, 1'b0, MOTION_NONE, 16'd0, 16'd0},
      '{16'd100,   1'b0, 1'b0, MOTION_NONE, 16'd0, 16'd0},
      '{16'd0,     1'b0, 1'b0, MOTION_NONE, 16'd0, 16'd0},
      '{16'd0,     1'b0, 1'b0, MOTION_NONE, 16'd0, 16'd0},
      '{16'd65535, 1'b1, 1'b1, MOTION_NONE, 16'd0, 16'd0},
      '{16'd0,     1'b0, 1'b0, MOTION_NONE, 16'd0, 16'd0},
      '{16'd65535, 1'b0, 1'b0, MOTION_NONE, 16'd0, 16'd0},
      '{16'd1,     1'b0, 1'b0, MOTION_NONE, 16'd0, 16'd0},
      '{16'd65535, 1'b0, 1'b0, MOTION_NONE, 16'd0, 16'd0},
      '{16'd65535, 1'b0, 1'b0, MOTION_NONE, 16'd0, 16'd0},
      '{16'd1,     1'b0, 1'b0, MOTION_NONE, 16'd0, 16'd0}
   };

   proximity_wave_hold_gesture_detector DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_prox         (req_prox),
      .req_clear_counts (req_clear_counts),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_gesture      (rsp_gesture),
      .rsp_wave_total   (rsp_wave_total),
      .rsp_hold_total   (rsp_hold_total),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic tally_word_type predict_gesture(input logic [PROX_BITS-1:0] prox,
                                                      input logic clear);
      tally_word_type r;
      mode_type entry_mode;
      int signed gap;
      int signed next_floor;
      logic [PROX_BITS-1:0] impulse;
      bit over;
      r.gesture = MOTION_NONE;
      if (clear) begin
         wave_tally = '0;
         hold_tally = '0;
      end
      if (prev_live) begin
         entry_mode = track_mode;
         gap = $signed({16'd0, prox}) - $signed({16'd0, floor_level});
         next_floor = $signed({16'd0, floor_level}) + gap / 32;
         if (next_floor > $signed({16'd0, prox}))
            next_floor = $signed({16'd0, prox});
         floor_level = next_floor[PROX_BITS-1:0];
         impulse = prox - floor_level;
         over = impulse > live_cfg.detect_threshold;
         case (track_mode)
            MODE_IDLE: begin
               track_mode = over ? MODE_LEVEL : MODE_ARMED;
               run_len = '0;
               r.gesture = MOTION_EXIT;
            end
            MODE_ARMED: begin
               if (over) begin
                  track_mode = MODE_LEVEL;
                  run_len = '0;
               end
            end
            MODE_LEVEL: begin
               if (!over || run_len > live_cfg.hold_min_frames) begin
                  if (run_len > live_cfg.hold_min_frames) begin
                     if (hold_tally != 16'hFFFF)
                        hold_tally = hold_tally + 1'b1;
                     track_mode = MODE_HOLD;
                     r.gesture = MOTION_HOLD;
                  end else if (run_len > live_cfg.wave_min_frames) begin
                     if (wave_tally != 16'hFFFF)
                        wave_tally = wave_tally + 1'b1;
                     track_mode = MODE_IDLE;
                     r.gesture = MOTION_WAVE;
                  end else begin
                     track_mode = MODE_IDLE;
                  end
                  run_len = '0;
               end
            end
            default: begin
               if (!over) begin
                  track_mode = MODE_IDLE;
                  run_len = '0;
               end
            end
         endcase
         if (over) begin
            if (run_len != 8'hFF)
               run_len = run_len + 1'b1;
         end else begin
            run_len = '0;
         end
         if (entry_mode != MODE_IDLE && track_mode == MODE_IDLE)
            floor_level = prox;
      end else begin
         floor_level = prox;
      end
      prev_live = (prox != '0);
      r.waves = wave_tally;
      r.holds = hold_tally;
      return r;
   endfunction

   task automatic send_word(input logic [PROX_BITS-1:0] prox, input logic clear,
                            input bit typed, input tally_word_type want);
      int gap;
      tally_word_type got;
      gap = burst ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_prox <= prox;
      req_clear_counts <= clear;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      got = predict_gesture(prox, clear);
      if (got.gesture == MOTION_WAVE)
         waves_predicted++;
      if (got.gesture == MOTION_HOLD)
         holds_predicted++;
      awaited_tallies.push_back(typed ? want : got);
      words_sent++;
   endtask

   task automatic settle_block();
      req_valid <= 1'b0;
      while (awaited_tallies.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_transfer(input logic wr, input logic [CSR_ADDR_BITS-1:0] addr,
                               input logic [CSR_DATA_BITS-1:0] data,
                               output logic [CSR_DATA_BITS-1:0] rdata);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= wr;
      csr_paddr <= addr;
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      rdata = csr_prdata;
   endtask

   task automatic check_register(input logic [CSR_ADDR_BITS-1:0] addr,
                                 input logic [CSR_DATA_BITS-1:0] value);
      logic [CSR_DATA_BITS-1:0] echo;
      csr_transfer(1'b0, addr, $urandom(), echo);
      if (echo !== value) begin
         $error("register %0h: expected %0h, got %0h", addr, value, echo);
         mismatches++;
      end
   endtask

   task automatic program_register(input logic [CSR_ADDR_BITS-1:0] addr,
                                   input logic [CSR_DATA_BITS-1:0] value, input int bits);
      logic [CSR_DATA_BITS-1:0] junk;
      logic [CSR_DATA_BITS-1:0] echo;
      junk = $urandom();
      csr_transfer(1'b1, addr, (junk << bits) | value, echo);
      check_register(addr, value);
   endtask

   task automatic apply_settings(input logic [THRESHOLD_BITS-1:0] thr,
                                 input logic [FRAMES_BITS-1:0] wave_min,
                                 input logic [FRAMES_BITS-1:0] hold_min);
      program_register(CSR_ADDR_THRESHOLD, thr, THRESHOLD_BITS);
      program_register(CSR_ADDR_WAVE_MIN, wave_min, FRAMES_BITS);
      program_register(CSR_ADDR_HOLD_MIN, hold_min, FRAMES_BITS);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      live_cfg = '{thr, wave_min, hold_min};
   endtask

   task automatic push_sample(input int prox);
      script.push_back('{prox[PROX_BITS-1:0], $urandom_range(0, 39) == 0});
   endtask

   task automatic plan_segment();
      int kind;
      int level;
      int lift;
      int ramp;
      int len;
      int high;
      kind = $urandom_range(0, 9);
      level = $urandom_range(1, 3000);
      lift = 2 * live_cfg.detect_threshold + $urandom_range(40, 600);
      if (lift > 65535 - level)
         lift = 65535 - level;
      ramp = live_cfg.detect_threshold / 24 + 2;
      if (kind <= 5) begin
         repeat ($urandom_range(1, 3)) push_sample(level);
         case ($urandom_range(0, 2))
            0: len = $urandom_range(1, live_cfg.wave_min_frames + 3);
            1: len = live_cfg.wave_min_frames + $urandom_range(1, 4);
            default: len = live_cfg.hold_min_frames + $urandom_range(0, 5);
         endcase
         for (int i = 0; i < len; i++) begin
            high = level + lift + i * ramp;
            push_sample(high > 65535 ? 65535 : high);
         end
         if ($urandom_range(0, 3) == 0)
            push_sample(0);
         else
            repeat ($urandom_range(1, 3)) push_sample(level);
      end else if (kind == 6) begin
         repeat ($urandom_range(1, 3)) push_sample(0);
         push_sample($urandom_range(0, 65535));
      end else if (kind == 7) begin
         repeat ($urandom_range(1, 6)) push_sample($urandom_range(0, 65535));
      end else if (kind == 8) begin
         push_sample(0);
         push_sample(65535);
         push_sample(1);
         push_sample(65535);
      end else begin
         push_sample(level);
         push_sample(level + lift);
         push_sample(0);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_hold_off <= 0;
      end else if (rsp_valid && rsp_ready) begin
         if (awaited_tallies.size() == 0) begin
            $error("unexpected word: gesture %0d, waves %0d, holds %0d",
                   rsp_gesture, rsp_wave_total, rsp_hold_total);
            mismatches++;
         end else begin
            no_tally = awaited_tallies.pop_front();
            if (rsp_gesture !== no_tally.gesture) begin
               $error("gesture: expected %0d, got %0d", no_tally.gesture, rsp_gesture);
               mismatches++;
            end
            if (rsp_wave_total !== no_tally.waves) begin
               $error("wave_total: expected %0d, got %0d", no_tally.waves, rsp_wave_total);
               mismatches++;
            end
            if (rsp_hold_total !== no_tally.holds) begin
               $error("hold_total: expected %0d, got %0d", no_tally.holds, rsp_hold_total);
               mismatches++;
            end
         end
         words_checked++;
         rsp_draw = burst ? 0 : $urandom_range(0, 10);
         rsp_ready <= (rsp_draw == 0);
         rsp_hold_off <= rsp_draw;
      end else if (!rsp_ready) begin
         if (rsp_hold_off <= 1) begin
            rsp_ready <= 1'b1;
            rsp_hold_off <= 0;
         end else begin
            rsp_hold_off <= rsp_hold_off - 1;
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("proximity_wave_hold_gesture_detector: mismatch");
      $finish;
   end

   initial begin
      tally_word_type want;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_prox <= '0;
      req_clear_counts <= 1'b0;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= '0;
      csr_pwdata <= '0;
      burst = 1'b0;
      mismatches = 0;
      words_sent = 0;
      words_checked = 0;
      waves_predicted = 0;
      holds_predicted = 0;
      live_cfg = '{THRESHOLD_RESET, WAVE_MIN_RESET, HOLD_MIN_RESET};
      track_mode = MODE_IDLE;
      run_len = '0;
      floor_level = '0;
      prev_live = 1'b0;
      wave_tally = '0;
      hold_tally = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      check_register(CSR_ADDR_THRESHOLD, THRESHOLD_RESET);
      check_register(CSR_ADDR_WAVE_MIN, WAVE_MIN_RESET);
      check_register(CSR_ADDR_HOLD_MIN, HOLD_MIN_RESET);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;

      foreach (opening_rows[i]) begin
         want = '{opening_rows[i].gesture, opening_rows[i].waves, opening_rows[i].holds};
         send_word(opening_rows[i].prox, opening_rows[i].clear, opening_rows[i].typed, want);
      end

      for (int p = 0; p < 6; p++) begin
         settle_block();
         case (p)
            0: apply_settings(16'd0, 8'd0, 8'd0);
            1: apply_settings(16'd65535, 8'd254, 8'd254);
            2: apply_settings(THRESHOLD_BITS'($urandom_range(1, 300)),
                              FRAMES_BITS'($urandom_range(0, 6)),
                              FRAMES_BITS'($urandom_range(7, 40)));
            3: apply_settings(16'd0, 8'd254, 8'd0);
            4: apply_settings(THRESHOLD_BITS'($urandom_range(0, 120)),
                              FRAMES_BITS'($urandom_range(0, 3)),
                              FRAMES_BITS'($urandom_range(4, 12)));
            default: apply_settings(THRESHOLD_BITS'($urandom_range(0, 65535)),
                                    FRAMES_BITS'($urandom_range(0, 254)),
                                    FRAMES_BITS'($urandom_range(0, 254)));
         endcase
         burst = (p == 4);
         while (script.size() < PHASE_WORDS) plan_segment();
         while (script.size() != 0) begin
            want = '{MOTION_NONE, 16'd0, 16'd0};
            send_word(script[0].prox, script[0].clear, 1'b0, want);
            script.delete(0);
         end
      end

      want = '{MOTION_NONE, 16'd0, 16'd0};
      burst = 1'b0;
      send_word(16'd500, 1'b1, 1'b0, want);
      send_word(16'd5000, 1'b0, 1'b0, want);
      send_word(16'd0, 1'b0, 1'b0, want);

      settle_block();
      repeat (6) @(posedge clock);
      $display("%0d sample words sent, %0d results checked, %0d waves and %0d holds expected",
               words_sent, words_checked, waves_predicted, holds_predicted);
      $display("register extremes, random settings, noise bursts and stalls on both sides");
      if (mismatches == 0)
         $display("proximity_wave_hold_gesture_detector: match");
      else
         $display("proximity_wave_hold_gesture_detector: mismatch");
      $finish;
   end

endmodule
